### hw/rtl/lzss_2k_window_decoder_defines.svh
`ifndef LZSS_2K_WINDOW_DECODER_DEFINES_SVH
`define LZSS_2K_WINDOW_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LZSS2K_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lzss2k assertion failed");

// next-cycle implication, checked outside reset
`define LZSS2K_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lzss2k assertion failed");

`endif

### hw/rtl/lzss2k_pkg.sv
package lzss2k_pkg;

   localparam int unsigned LEN_W     = 24;
   localparam int unsigned POS_W     = 11;
   localparam int unsigned RUN_W     = 6;
   localparam logic [POS_W-1:0] WIN_START = 11'h7F7;
   localparam logic [RUN_W-1:0] MIN_RUN   = 6'd3;
   localparam logic [3:0]       FLAGS_PER_BYTE = 4'd8;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY
   } ctrl_state_type;

   typedef enum logic [1:0] {
      TOK_FLAG,
      TOK_LITERAL,
      TOK_MATCH_HI,
      TOK_MATCH_LO
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   match_high;
   } token_type;

endpackage

### hw/rtl/lzss2k_ram.sv
module lzss2k_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/lzss2k_token.sv
module lzss2k_token
   import lzss2k_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   output token_type  token
);

   logic [7:0] flags_ff, flags_in;
   logic [3:0] left_ff, left_in;
   logic       phase_ff, phase_in;
   logic [7:0] high_ff, high_in;

   always_comb begin
      token.match_high = high_ff;
      if (phase_ff) begin
         token.kind = TOK_MATCH_LO;
      end else if (left_ff == '0) begin
         token.kind = TOK_FLAG;
      end else if (flags_ff[7]) begin
         token.kind = TOK_MATCH_HI;
      end else begin
         token.kind = TOK_LITERAL;
      end
   end

   always_comb begin
      flags_in = flags_ff;
      left_in  = left_ff;
      phase_in = phase_ff;
      high_in  = high_ff;
      if (step) begin
         unique case (token.kind)
            TOK_MATCH_LO: begin
               phase_in = 1'b0;
            end
            TOK_FLAG: begin
               flags_in = in_byte;
               left_in  = FLAGS_PER_BYTE;
            end
            TOK_MATCH_HI: begin
               flags_in = {flags_ff[6:0], 1'b0};
               left_in  = left_ff - 4'd1;
               high_in  = in_byte;
               phase_in = 1'b1;
            end
            TOK_LITERAL: begin
               flags_in = {flags_ff[6:0], 1'b0};
               left_in  = left_ff - 4'd1;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         left_ff  <= '0;
         phase_ff <= 1'b0;
         high_ff  <= '0;
      end else begin
         flags_ff <= flags_in;
         left_ff  <= left_in;
         phase_ff <= phase_in;
         high_ff  <= high_in;
      end
   end

endmodule

### hw/rtl/lzss_2k_window_decoder.sv
// LZSS decoder over a 2048-byte history window. After reset the window RAM is
// swept to zero, one entry per cycle; requests wait during the sweep while
// csr writes are taken at once. A flag byte, a match high byte or a literal
// is handled in the idle state. A match low byte starts a copy of 3 to 34
// bytes (fewer if the programmed length is reached) that runs at one byte per
// cycle while rsp_tready allows, bounded by the single read and single write
// port of the window RAM, so it holds off the next request until its last
// byte is emitted. Once the count of produced bytes reaches the programmed
// length, requests are taken and dropped without effect.
`include "lzss_2k_window_decoder_defines.svh"

module lzss_2k_window_decoder
   import lzss2k_pkg::*;
#(
   parameter int unsigned WINDOW_SIZE = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] in_byte
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,   // run_last
   output logic             rsp_tuser,   // [0] stream_done
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_data    // output_length
);

   localparam int unsigned ADDR_W = $clog2(WINDOW_SIZE);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(WINDOW_SIZE - 1);

   ctrl_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] wpos_ff, wpos_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [RUN_W-1:0]  remain_ff, remain_in;
   logic [LEN_W-1:0]  produced_ff, produced_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [7:0]        fwd_data_ff, fwd_data_in;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata, ram_rdata;

   token_type         token;
   logic              out_free, done, req_fire, tok_step;
   logic              emit, emit_last, emit_done;
   logic [7:0]        emit_byte;
   logic [LEN_W-1:0]  produced_next;
   logic              copy_last;

   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign done          = produced_ff >= length_ff;
   assign req_tready    = (state_ff == ST_IDLE) && out_free;
   assign req_fire      = req_tvalid && req_tready;
   assign tok_step      = req_fire && !done;
   assign produced_next = produced_ff + LEN_W'(1);
   assign emit_done     = produced_next >= length_ff;
   assign copy_last     = (remain_ff == RUN_W'(1)) || emit_done;

   lzss2k_token u_token (
      .clock   (clock),
      .reset   (reset),
      .step    (tok_step),
      .in_byte (req_tdata),
      .token   (token)
   );

   lzss2k_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_SIZE)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (tok_step && token.kind == TOK_MATCH_LO) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (out_free && copy_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // window accesses and emitted byte
   always_comb begin
      emit      = 1'b0;
      emit_byte = req_tdata;
      emit_last = 1'b1;
      ram_re    = 1'b0;
      ram_raddr = src_ff;
      ram_we    = 1'b0;
      ram_waddr = wpos_ff;
      ram_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
         end
         ST_IDLE: begin
            if (tok_step && token.kind == TOK_LITERAL) begin
               emit = 1'b1;
            end
            if (tok_step && token.kind == TOK_MATCH_LO) begin
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'({token.match_high[2:0], req_tdata});
            end
         end
         ST_COPY: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = fwd_hit_ff ? fwd_data_ff : ram_rdata;
               emit_last = copy_last;
               if (!copy_last) begin
                  ram_re = 1'b1;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      if (emit) begin
         ram_we    = 1'b1;
         ram_waddr = wpos_ff;
         ram_wdata = emit_byte;
      end
   end

   always_comb begin
      clr_addr_in  = clr_addr_ff + ADDR_W'(1);
      wpos_in      = wpos_ff;
      src_in       = src_ff;
      remain_in    = remain_ff;
      produced_in  = produced_ff;
      length_in    = csr_valid ? csr_data : length_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_data_in  = fwd_data_ff;
      if (ram_re) begin
         src_in      = ram_raddr + ADDR_W'(1);
         fwd_hit_in  = ram_we && (ram_waddr == ram_raddr);
         fwd_data_in = ram_wdata;
      end
      if (state_ff == ST_IDLE && tok_step && token.kind == TOK_MATCH_LO) begin
         remain_in = RUN_W'(token.match_high[7:3]) + MIN_RUN;
      end
      if (emit) begin
         wpos_in      = wpos_ff + ADDR_W'(1);
         produced_in  = produced_next;
         remain_in    = remain_ff - RUN_W'(1);
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
         rsp_done_in  = emit_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wpos_ff      <= ADDR_W'(WIN_START);
         remain_ff    <= '0;
         produced_ff  <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wpos_ff      <= wpos_in;
         remain_ff    <= remain_in;
         produced_ff  <= produced_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
      fwd_data_ff <= fwd_data_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

   `LZSS2K_ASSERT_NOW(a_no_request_in_clear, state_ff == ST_CLEAR, !req_tready)
   `LZSS2K_ASSERT_NOW(a_done_ends_run, rsp_valid_ff && rsp_done_ff, rsp_last_ff)
   `LZSS2K_ASSERT_NOW(a_copy_has_bytes, state_ff == ST_COPY, remain_ff != '0)
   `LZSS2K_ASSERT_NEXT(a_emit_shows_rsp, emit, rsp_valid_ff)

endmodule
